/* rtl/core/jsu_pkg.sv */
`default_nettype none

package jsu_pkg;

	// result codes
	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_OK   = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	// decoder phases
	typedef enum logic [1:0] {
		PH_WAIT = 2'd0,
		PH_STR  = 2'd1,
		PH_ESC  = 2'd2,
		PH_HEX  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       source_end;
	} src_t;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      kind;
		logic       last;
	} res_t;

	// all results caused by one source byte
	typedef struct packed {
		logic [1:0]      cnt;
		kind_t           kind;
		logic [2:0][7:0] data;
	} grp_t;

	localparam int GRP_DEPTH_DFLT = 4;

	localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF8_CONT  = 8'h80;
	localparam logic [7:0]  UTF8_MASK6 = 8'h3F;
	localparam logic [15:0] UTF8_LIM1  = 16'h0080;
	localparam logic [15:0] UTF8_LIM2  = 16'h0800;

endpackage

`default_nettype wire

/* rtl/core/json_string_unescape.sv */
// A source byte passes the input register, group queue and output register in turn.
// Throughput: one source byte and one result per cycle, each unless stalled.
// A \u escape yields up to three results from one byte; the group queue absorbs
// these bursts and the source side stalls only while the queue is full.
// Reset (arst_n low, asynchronous): decoder waits for an opening quote, queues empty.
`default_nettype none

module json_string_unescape #(
	parameter int GRP_DEPTH = jsu_pkg::GRP_DEPTH_DFLT
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           src_valid,
	output logic          src_stall,
	input  jsu_pkg::src_t src_data,
	output logic          res_valid,
	input  wire           res_stall,
	output jsu_pkg::res_t res_data
);
	import jsu_pkg::*;

	// input register
	logic vld_s1;
	src_t src_s1;

	grp_t grp;
	logic grp_push;
	grp_t head;
	logic head_vld;
	logic grp_full;
	logic grp_pop;
	logic dec_en;

	// the registered byte is decoded as soon as the queue has room; the stall
	// comes from registers only, so it never waits on the source valid
	assign dec_en    = vld_s1 && !grp_full;
	assign src_stall = vld_s1 && grp_full;

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) src_s1 <= src_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!src_stall) begin
			vld_s1 <= src_valid;
		end
	end

	// escape and UTF-8 decode; bytes that yield nothing (outer whitespace, open quote,
	// backslash, u, hex digits before the last) update state without a queue transfer
	jsu_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (dec_en),
		.src    (src_s1),
		.grp    (grp),
		.push   (grp_push)
	);

	// one entry per source byte that yields results, holding all of them
	jsu_fifo #(
		.DEPTH (GRP_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (grp_push),
		.wdata  (grp),
		.pop    (grp_pop),
		.head   (head),
		.nempty (head_vld),
		.full   (grp_full)
	);

	// walks the head entry one result per transfer, marks the final one last
	jsu_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_vld  (head_vld),
		.pop       (grp_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

`default_nettype wire

/* rtl/core/jsu_decode.sv */
`default_nettype none

module jsu_decode (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           en,
	input  jsu_pkg::src_t src,
	output jsu_pkg::grp_t grp,
	output logic          push
);
	import jsu_pkg::*;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_U     = 8'h75;

	phase_t      phase_q, phase_d;
	logic [1:0]  hex_left_q, hex_left_d;
	logic [15:0] code_q, code_d;

	logic [7:0]  c;
	logic        is_ws;
	logic        hex_ok;
	logic [3:0]  hex_v;
	logic        esc_ok;
	logic [7:0]  esc_b;
	logic [15:0] code_nx;

	assign c = src.in_byte;
	assign is_ws = (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	assign code_nx = {code_q[11:0], hex_v};

	always_comb begin
		hex_ok = 1'b1;
		hex_v  = 4'd0;
		case (c) inside
			[8'h30:8'h39]: hex_v = c[3:0];
			[8'h41:8'h46],
			[8'h61:8'h66]: hex_v = 4'(c[2:0] + 3'd1) + 4'd8;
			default:       hex_ok = 1'b0;
		endcase
	end

	always_comb begin
		esc_ok = 1'b1;
		esc_b  = c;
		case (c)
			CH_QUOTE, CH_BSL, 8'h2F: esc_b = c;
			8'h62:   esc_b = 8'h08;
			8'h66:   esc_b = 8'h0C;
			8'h6E:   esc_b = 8'h0A;
			8'h72:   esc_b = 8'h0D;
			8'h74:   esc_b = 8'h09;
			default: esc_ok = 1'b0;
		endcase
	end

	function automatic grp_t utf8(input logic [15:0] cp);
		grp_t g;
		g      = '0;
		g.kind = KIND_BYTE;
		if (cp < UTF8_LIM1) begin
			g.cnt     = 2'd1;
			g.data[0] = cp[7:0];
		end else if (cp < UTF8_LIM2) begin
			g.cnt     = 2'd2;
			g.data[0] = UTF8_LEAD2 | {3'b0, cp[10:6]};
			g.data[1] = UTF8_CONT | ({2'b0, cp[5:0]} & UTF8_MASK6);
		end else begin
			g.cnt     = 2'd3;
			g.data[0] = UTF8_LEAD3 | {4'b0, cp[15:12]};
			g.data[1] = UTF8_CONT | {2'b0, cp[11:6]};
			g.data[2] = UTF8_CONT | {2'b0, cp[5:0]};
		end
		return g;
	endfunction

	// next state
	always_comb begin
		phase_d    = phase_q;
		hex_left_d = hex_left_q;
		code_d     = code_q;
		if (en) begin
			if (src.source_end) begin
				phase_d    = PH_WAIT;
				hex_left_d = 2'd0;
				code_d     = '0;
			end else begin
				case (phase_q)
					PH_WAIT: begin
						if (c == CH_QUOTE) phase_d = PH_STR;
					end
					PH_STR: begin
						if (c == CH_QUOTE) phase_d = PH_WAIT;
						else if (c == CH_BSL) phase_d = PH_ESC;
					end
					PH_ESC: begin
						if (c == CH_U) begin
							phase_d    = PH_HEX;
							hex_left_d = 2'd3;
							code_d     = '0;
						end else if (esc_ok) begin
							phase_d = PH_STR;
						end else begin
							phase_d    = PH_WAIT;
							hex_left_d = 2'd0;
							code_d     = '0;
						end
					end
					PH_HEX: begin
						if (!hex_ok) begin
							phase_d    = PH_WAIT;
							hex_left_d = 2'd0;
							code_d     = '0;
						end else if (hex_left_q == 2'd0) begin
							phase_d = PH_STR;
							code_d  = '0;
						end else begin
							hex_left_d = hex_left_q - 2'd1;
							code_d     = code_nx;
						end
					end
					default: phase_d = PH_WAIT;
				endcase
			end
		end
	end

	// results
	always_comb begin
		grp      = '0;
		grp.kind = KIND_BYTE;
		if (src.source_end) begin
			grp.cnt  = 2'd1;
			grp.kind = KIND_ERR;
		end else begin
			case (phase_q)
				PH_WAIT: begin
					if (c != CH_QUOTE && !is_ws) begin
						grp.cnt  = 2'd1;
						grp.kind = KIND_ERR;
					end
				end
				PH_STR: begin
					if (c == CH_QUOTE) begin
						grp.cnt  = 2'd1;
						grp.kind = KIND_OK;
					end else if (c != CH_BSL) begin
						grp.cnt     = 2'd1;
						grp.data[0] = c;
					end
				end
				PH_ESC: begin
					if (c == CH_U) begin
						grp.cnt = 2'd0;
					end else if (esc_ok) begin
						grp.cnt     = 2'd1;
						grp.data[0] = esc_b;
					end else begin
						grp.cnt  = 2'd1;
						grp.kind = KIND_ERR;
					end
				end
				PH_HEX: begin
					if (!hex_ok) begin
						grp.cnt  = 2'd1;
						grp.kind = KIND_ERR;
					end else if (hex_left_q == 2'd0) begin
						grp = utf8(code_nx);
					end
				end
				default: grp.cnt = 2'd0;
			endcase
		end
	end

	assign push = en && (grp.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT;
			hex_left_q <= 2'd0;
			code_q     <= '0;
		end else begin
			phase_q    <= phase_d;
			hex_left_q <= hex_left_d;
			code_q     <= code_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/jsu_fifo.sv */
`default_nettype none

module jsu_fifo #(
	parameter int DEPTH = jsu_pkg::GRP_DEPTH_DFLT
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           push,
	input  jsu_pkg::grp_t wdata,
	input  wire           pop,
	output jsu_pkg::grp_t head,
	output logic          nempty,
	output logic          full
);
	import jsu_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	grp_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	assign nempty = (cnt_q != '0);
	assign full   = (cnt_q == (AW+1)'(DEPTH));
	assign head   = mem_q[rd_q];

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= bump(wr_q);
			if (pop)  rd_q <= bump(rd_q);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/jsu_serial.sv */
`default_nettype none

module jsu_serial (
	input  wire           clk,
	input  wire           arst_n,
	input  jsu_pkg::grp_t head,
	input  wire           head_vld,
	output logic          pop,
	output logic          res_valid,
	input  wire           res_stall,
	output jsu_pkg::res_t res_data
);
	import jsu_pkg::*;

	logic       vld_q;
	res_t       res_q;
	logic [1:0] idx_q;
	logic       load;
	logic       at_end;
	logic [7:0] sel_b;

	assign load   = !vld_q || !res_stall;
	assign at_end = (idx_q == head.cnt - 2'd1);
	assign pop    = load && head_vld && at_end;

	always_comb begin
		case (idx_q)
			2'd0:    sel_b = head.data[0];
			2'd1:    sel_b = head.data[1];
			default: sel_b = head.data[2];
		endcase
	end

	always_ff @(posedge clk) begin
		if (load && head_vld) begin
			res_q.out_byte <= sel_b;
			res_q.kind     <= head.kind;
			res_q.last     <= at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (load) begin
			vld_q <= head_vld;
			if (head_vld) idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
		end
	end

	assign res_valid = vld_q;
	assign res_data  = res_q;

endmodule

`default_nettype wire

/* rtl/core/jsu_checker.sv */
`default_nettype none

module jsu_checker (
	input wire           clk,
	input wire           arst_n,
	input wire           src_stall,
	input wire           res_valid,
	input wire           res_stall,
	input jsu_pkg::res_t res_data
);
	import jsu_pkg::*;

	// handshake outputs come from reset registers
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(src_stall) && !$isunknown(res_valid))
		else $error("handshake output unknown");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// status results are single, zero-byte and last
	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.kind != KIND_BYTE) |->
			(res_data.out_byte == 8'd0) && res_data.last)
		else $error("status result malformed");

	// a multi-byte sequence continues without a gap
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res_data.last |=>
			res_valid && (res_data.kind == KIND_BYTE))
		else $error("UTF-8 sequence broken");

	// a non-last result is always a decoded byte
	a_nonlast_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.last |-> res_data.kind == KIND_BYTE)
		else $error("non-last status result");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (.*);

`default_nettype wire
